[design/swrm_pkg.sv]
package swrm_pkg;

	localparam int ITEM_TYPES_DEF  = 64;
	localparam int MAX_BUCKETS_DEF = 128;
	localparam logic [7:0] WINDOW_RESET = 8'd120;
	localparam int DIV_STEPS = 48;

	typedef struct packed {
		logic [5:0]  item_type;
		logic        is_consumption;
		logic [31:0] bucket_index;
		logic [19:0] quantity;
	} swrm_in_t;

	typedef struct packed {
		logic [39:0] rolling_sum;
		logic [7:0]  bucket_count;
		logic [47:0] rate_per_bucket;
	} swrm_out_t;

endpackage

[design/swrm_ram.sv]
module swrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/bucketed_sliding_window_rate_meter.sv]
// bucketed sliding-window rate meter. every item type has a production and a
// consumption window (window number = item_type * 2 + is_consumption); each is
// a ring of time buckets with a running sum. a beat on the input moves its
// window up to bucket_index (appending empty buckets, dropping the oldest past
// window_buckets), adds quantity to the newest bucket (saturating at 32 bits)
// and returns one beat: the sum, the bucket count and floor(sum * 256 / count).
// type 0 or a type at or above ITEM_TYPES gives an all-zero beat and changes
// nothing; window_buckets 0 empties the window and gives zeros. one item is
// handled at a time by a small sequencer around one bucket ram and a
// bit-serial divider: appended buckets are written one at a time, each
// dropping the oldest one first once the window is full (up to MAX_BUCKETS
// of each), then the add and the divide, then the result waits for out_stall low.
// after reset and after every window_buckets write the per-window state ram
// is cleared one window per cycle (all 2 * ITEM_TYPES windows) while in_stall is
// held high; configuration writes are always taken (cfg_ready is tied high).
module bucketed_sliding_window_rate_meter #(
	parameter int ITEM_TYPES  = swrm_pkg::ITEM_TYPES_DEF,
	parameter int MAX_BUCKETS = swrm_pkg::MAX_BUCKETS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  swrm_pkg::swrm_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output swrm_pkg::swrm_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	import swrm_pkg::*;

	localparam int WIN = 2 * ITEM_TYPES;
	localparam int WW  = $clog2(WIN);
	localparam int SW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int BD  = WIN * MAX_BUCKETS;
	localparam int AW  = $clog2(BD);
	localparam int MW  = 32 + SW + 8 + 40;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_META_RD = 12'b000000000010,
		S_META    = 12'b000000000100,
		S_ADV     = 12'b000000001000,
		S_PUSH    = 12'b000000010000,
		S_DROP_RD = 12'b000000100000,
		S_DROP    = 12'b000001000000,
		S_ADD_RD  = 12'b000010000000,
		S_ADD     = 12'b000100000000,
		S_WB      = 12'b001000000000,
		S_DIV     = 12'b010000000000,
		S_OUT     = 12'b100000000000
	} state_t;

	state_t      state_q;
	logic [7:0]  wbuck_q;
	logic        clr_q;
	logic [WW-1:0] clr_cnt_q;

	// item being worked on
	logic [WW-1:0] win_q;
	logic [31:0]   now_q;
	logic [19:0]   qty_q;
	logic          zero_q;

	// window state copied out of the ram
	logic [31:0]   newest_q;
	logic [SW-1:0] oldest_q;
	logic [7:0]    held_q;
	logic [39:0]   sum_q;
	logic [7:0]    rem_q;

	// divider
	logic [47:0]   dq_q;
	logic [7:0]    drem_q;
	logic [5:0]    dcnt_q;

	swrm_out_t     out_q;

	// per-window state ram
	logic          meta_we;
	logic [WW-1:0] meta_waddr;
	logic [MW-1:0] meta_wdata;
	logic [MW-1:0] meta_rdata;

	// bucket ram
	logic          bk_we;
	logic [AW-1:0] bk_waddr;
	logic [AW-1:0] bk_raddr;
	logic [31:0]   bk_wdata;
	logic [31:0]   bk_rdata;

	logic [7:0]    limit;
	logic [9:0]    app_sum;
	logic [SW-1:0] app_slot;
	logic [SW-1:0] new_slot;
	logic [SW-1:0] old_next;
	logic [31:0]   gap;
	logic [31:0]   room;
	logic [31:0]   add_amt;
	logic [8:0]    dtry;
	logic          dfit;
	logic [WW-1:0] in_win;
	logic          in_ok;

	assign limit = (16'(wbuck_q) > 16'(MAX_BUCKETS)) ? 8'(MAX_BUCKETS) : wbuck_q;

	// slot after the newest one, and the newest one itself, modulo the ring size
	always_comb begin
		app_sum = 10'(oldest_q) + 10'(held_q);
		if (app_sum >= 10'(MAX_BUCKETS)) begin
			app_slot = SW'(app_sum - 10'(MAX_BUCKETS));
		end else begin
			app_slot = SW'(app_sum);
		end
		if (app_sum - 10'd1 >= 10'(MAX_BUCKETS)) begin
			new_slot = SW'(app_sum - 10'd1 - 10'(MAX_BUCKETS));
		end else begin
			new_slot = SW'(app_sum - 10'd1);
		end
		old_next = (oldest_q == SW'(MAX_BUCKETS - 1)) ? '0 : oldest_q + SW'(1);
	end

	assign gap     = now_q - newest_q;
	assign room    = ~bk_rdata;
	assign add_amt = (32'(qty_q) > room) ? room : 32'(qty_q);
	assign dtry    = {drem_q, dq_q[47]};
	assign dfit    = dtry >= {1'b0, held_q};
	assign in_win  = WW'({in_data.item_type, in_data.is_consumption});
	assign in_ok   = (in_data.item_type != 6'd0) && (32'(in_data.item_type) < 32'(ITEM_TYPES));

	assign in_stall  = clr_q || (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// state ram: clearing sweep or write-back of the worked window
	assign meta_we    = clr_q || (state_q == S_WB);
	assign meta_waddr = clr_q ? clr_cnt_q : win_q;
	assign meta_wdata = clr_q ? '0 : {newest_q, oldest_q, held_q, sum_q};

	// bucket ram: zero on append, saturated sum on add
	assign bk_we    = ((state_q == S_PUSH) && (rem_q != 8'd0) && (held_q < limit))
		|| (state_q == S_ADD);
	assign bk_waddr = AW'(win_q) * AW'(MAX_BUCKETS)
		+ AW'((state_q == S_ADD) ? new_slot : app_slot);
	assign bk_wdata = (state_q == S_ADD) ? bk_rdata + add_amt : 32'd0;
	assign bk_raddr = AW'(win_q) * AW'(MAX_BUCKETS)
		+ AW'((state_q == S_DROP_RD) ? oldest_q : new_slot);

	swrm_ram #(.WIDTH(MW), .DEPTH(WIN)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (win_q),
		.rdata (meta_rdata)
	);

	swrm_ram #(.WIDTH(32), .DEPTH(BD)) u_bucket (
		.clk   (clk),
		.we    (bk_we),
		.waddr (bk_waddr),
		.wdata (bk_wdata),
		.raddr (bk_raddr),
		.rdata (bk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wbuck_q   <= WINDOW_RESET;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			// clearing sweep over every window
			if (cfg_valid) begin
				wbuck_q   <= cfg_data;
				clr_q     <= 1'b1;
				clr_cnt_q <= '0;
			end else if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + WW'(1);
				if (clr_cnt_q == WW'(WIN - 1)) begin
					clr_q <= 1'b0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !clr_q) begin
						win_q <= in_win;
						now_q <= in_data.bucket_index;
						qty_q <= in_data.quantity;
						if (in_ok) begin
							state_q <= S_META_RD;
						end else begin
							out_q   <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_META_RD: state_q <= S_META;
				S_META: begin
					zero_q <= (limit == 8'd0);
					if (limit == 8'd0) begin
						// a zero-size window is emptied by every sample
						newest_q <= meta_rdata[MW-1 -: 32];
						oldest_q <= '0;
						held_q   <= 8'd0;
						sum_q    <= 40'd0;
						state_q  <= S_WB;
					end else begin
						{newest_q, oldest_q, held_q, sum_q} <= meta_rdata;
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (held_q == 8'd0 || (now_q > newest_q && gap >= 32'(limit))) begin
						// empty window or jump past its span: restart at now
						oldest_q <= '0;
						held_q   <= 8'd0;
						sum_q    <= 40'd0;
						newest_q <= now_q - 32'd1;
						rem_q    <= 8'd1;
					end else if (now_q > newest_q) begin
						rem_q <= 8'(gap);
					end else begin
						rem_q <= 8'd0;
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (rem_q == 8'd0) begin
						state_q <= (qty_q != 20'd0) ? S_ADD_RD : S_WB;
					end else if (held_q >= limit) begin
						state_q <= S_DROP_RD;
					end else begin
						held_q   <= held_q + 8'd1;
						newest_q <= newest_q + 32'd1;
						rem_q    <= rem_q - 8'd1;
					end
				end
				S_DROP_RD: state_q <= S_DROP;
				S_DROP: begin
					sum_q    <= sum_q - 40'(bk_rdata);
					oldest_q <= old_next;
					held_q   <= held_q - 8'd1;
					state_q  <= S_PUSH;
				end
				S_ADD_RD: state_q <= S_ADD;
				S_ADD: begin
					sum_q   <= sum_q + 40'(add_amt);
					state_q <= S_WB;
				end
				S_WB: begin
					if (zero_q) begin
						out_q   <= '0;
						state_q <= S_OUT;
					end else begin
						dq_q    <= {sum_q, 8'd0};
						drem_q  <= 8'd0;
						dcnt_q  <= 6'(DIV_STEPS - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					drem_q <= dfit ? 8'(dtry - {1'b0, held_q}) : dtry[7:0];
					dq_q   <= {dq_q[46:0], dfit};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd0) begin
						out_q.rolling_sum     <= sum_q;
						out_q.bucket_count    <= held_q;
						out_q.rate_per_bucket <= {dq_q[46:0], dfit};
						state_q               <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
